### design/brbf_pkg.sv
// shared types, constants and codes for the block ring byte fifo
package brbf_pkg;

    // store geometry
    localparam int STORE_DEPTH     = 1024;
    localparam int MAX_BLOCK_BYTES = 8;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int CNT_W           = 11;
    localparam int BCNT_W          = 4;
    localparam int IDX_W           = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int SLOT_W          = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
    localparam int DATA_W          = 64;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ZERO_COUNT  = 3'd1;
    localparam logic [2:0] ST_EXCEEDS_CAP = 3'd2;
    localparam logic [2:0] ST_NO_SPACE    = 3'd3;
    localparam logic [2:0] ST_NO_DATA     = 3'd4;

    // config register indexes
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BCNT_W-1:0] byte_count;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  readable_count;
        logic [CNT_W-1:0]  writable_count;
    } t_out_item;

    // byte store port request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_READ,
        S_COMMIT,
        S_RESULT
    } t_state;

endpackage

### design/brbf_ram.sv
// generic single-port ram with registered read
module brbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/brbf_ctrl.sv
// sequencer and byte-step datapath: checks, moves bytes one per cycle, keeps pointers
module brbf_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  brbf_pkg::t_in_item        i_item,
    input  logic [brbf_pkg::CNT_W-1:0] i_cap,
    input  logic                      i_clr_ptrs,
    input  logic                      i_res_take,
    input  logic [7:0]                i_ram_rdata,
    output brbf_pkg::t_ram_req        o_ram_req,
    output logic                      o_busy,
    output logic                      o_res_valid,
    output brbf_pkg::t_out_item       o_res
);
    import brbf_pkg::*;

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [BCNT_W-1:0]   r_cnt, n_cnt;
    logic [DATA_W-1:0]   r_wdata, n_wdata;
    logic [DATA_W-1:0]   r_rdata, n_rdata;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_rd_pend, n_rd_pend;
    logic [SLOT_W-1:0]   r_rd_slot, n_rd_slot;
    logic [2:0]          r_status, n_status;
    logic [ADDR_W-1:0]   r_rd_pos, n_rd_pos;
    logic [ADDR_W-1:0]   r_wr_pos, n_wr_pos;
    logic                r_full, n_full;

    logic [CNT_W-1:0]    readable, writable;
    logic [CNT_W-1:0]    cnt_ext, ptr_ext, rd_ext, wr_ext;
    logic [ADDR_W-1:0]   ptr_adv;
    logic                check_ok;
    logic                rd_issue;

    assign cnt_ext = CNT_W'(r_cnt);
    assign ptr_ext = CNT_W'(r_ptr);
    assign rd_ext  = CNT_W'(r_rd_pos);
    assign wr_ext  = CNT_W'(r_wr_pos);

    // occupancy from the pointers and the full flag
    always_comb begin
        if (r_full) begin
            readable = i_cap;
        end else if (wr_ext >= rd_ext) begin
            readable = wr_ext - rd_ext;
        end else begin
            readable = i_cap - (rd_ext - wr_ext);
        end
        writable = r_full ? '0 : (i_cap - readable);
    end

    // shared pointer step with wrap at capacity
    assign ptr_adv = ((ptr_ext + CNT_W'(1)) == i_cap) ? '0 : (r_ptr + ADDR_W'(1));

    // transfer checks in their priority order
    always_comb begin
        n_status = ST_OK;
        check_ok = 1'b0;
        if (r_op == OP_CLEAR) begin
            check_ok = 1'b1;
        end else if (r_op == OP_WRITE || r_op == OP_READ) begin
            if (r_cnt == '0) begin
                n_status = ST_ZERO_COUNT;
            end else if (cnt_ext > CNT_W'(MAX_BLOCK_BYTES)) begin
                n_status = ST_EXCEEDS_CAP;
            end else if (r_op == OP_WRITE) begin
                if (cnt_ext > i_cap) begin
                    n_status = ST_EXCEEDS_CAP;
                end else if (cnt_ext > writable) begin
                    n_status = ST_NO_SPACE;
                end else begin
                    check_ok = 1'b1;
                end
            end else begin
                if (cnt_ext > readable) begin
                    n_status = ST_NO_DATA;
                end else begin
                    check_ok = 1'b1;
                end
            end
        end
    end

    assign rd_issue = (IDX_W'(r_cnt) > r_idx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!check_ok) begin
                    n_state = S_RESULT;
                end else if (r_op == OP_WRITE) begin
                    n_state = S_WRITE;
                end else if (r_op == OP_READ) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_WRITE: begin
                if ((r_idx + IDX_W'(1)) == IDX_W'(r_cnt)) begin
                    n_state = S_COMMIT;
                end
            end
            S_READ: begin
                if (!rd_issue && !r_rd_pend) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ram_req.we    = (r_state == S_WRITE);
        o_ram_req.addr  = r_ptr;
        o_ram_req.wdata = r_wdata[7:0];
        o_busy          = (r_state != S_IDLE);
        o_res_valid     = (r_state == S_RESULT);
        o_res.status         = r_status;
        o_res.read_data      = r_rdata;
        o_res.readable_count = readable;
        o_res.writable_count = writable;
    end

    // datapath next values
    always_comb begin
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_wdata   = r_wdata;
        n_rdata   = r_rdata;
        n_ptr     = r_ptr;
        n_idx     = r_idx;
        n_rd_pend = 1'b0;
        n_rd_slot = r_rd_slot;
        n_rd_pos  = r_rd_pos;
        n_wr_pos  = r_wr_pos;
        n_full    = r_full;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_item.operation;
                    n_cnt   = i_item.byte_count;
                    n_wdata = i_item.write_data;
                end
            end
            S_CHECK: begin
                n_ptr   = (r_op == OP_WRITE) ? r_wr_pos : r_rd_pos;
                n_idx   = '0;
                n_rdata = '0;
            end
            S_WRITE: begin
                n_ptr   = ptr_adv;
                n_idx   = r_idx + IDX_W'(1);
                n_wdata = r_wdata >> 8;
            end
            S_READ: begin
                if (rd_issue) begin
                    n_ptr     = ptr_adv;
                    n_idx     = r_idx + IDX_W'(1);
                    n_rd_pend = 1'b1;
                    n_rd_slot = r_idx[SLOT_W-1:0];
                end
                // place the byte returned for the previous address
                if (r_rd_pend) begin
                    for (int k = 0; k < MAX_BLOCK_BYTES; k++) begin
                        if (r_rd_slot == SLOT_W'(k)) begin
                            n_rdata[8*k +: 8] = i_ram_rdata;
                        end
                    end
                end
            end
            S_COMMIT: begin
                if (r_op == OP_WRITE) begin
                    n_wr_pos = r_ptr;
                    n_full   = (r_ptr == r_rd_pos);
                end else if (r_op == OP_READ) begin
                    n_rd_pos = r_ptr;
                    n_full   = 1'b0;
                end else begin
                    n_rd_pos = '0;
                    n_wr_pos = '0;
                    n_full   = 1'b0;
                end
            end
            default: begin
            end
        endcase
        // capacity write restarts the ring
        if (i_clr_ptrs) begin
            n_rd_pos = '0;
            n_wr_pos = '0;
            n_full   = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_rd_pos  <= '0;
            r_wr_pos  <= '0;
            r_full    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            r_rd_pos  <= n_rd_pos;
            r_wr_pos  <= n_wr_pos;
            r_full    <= n_full;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_cnt     <= n_cnt;
        r_wdata   <= n_wdata;
        r_rdata   <= n_rdata;
        r_ptr     <= n_ptr;
        r_idx     <= n_idx;
        r_rd_slot <= n_rd_slot;
        if (r_state == S_CHECK) begin
            r_status <= n_status;
        end
    end

endmodule

### design/block_ring_byte_fifo.sv
// top level of the block ring byte fifo: channels, config port, byte store
//
// A circular byte fifo moved in blocks of 1 to 8 bytes. Each input transaction
// (operation, byte_count, write_data) writes a block, reads a block or clears
// the pointers; every one gives exactly one output transaction with a status,
// the bytes read (first byte in bits 7:0) and the readable and writable counts.
// A block that cannot move whole is refused and changes nothing.
// One item is worked at a time: o_in_stall is high from acceptance until its
// result is loaded into the output register. An item passes through the check,
// the byte steps of a write or read (a read waits for the registered store read),
// a commit and the result state; a refused or unused item goes from the check
// straight to the result. The bytes pass one per cycle through the single-port
// byte store, which sets the rate.
// The output register lets a new item be accepted while a result waits; when
// i_out_stall holds, the next result waits in the sequencer and input stalls.
// The capacity register sits at byte address 0 of the apb port; writing it
// also clears both positions and the full flag. Reset clears the positions,
// the full flag and both valids and sets capacity to the full store; the store
// contents are not cleared, and no byte can be read before it was written.
module block_ring_byte_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  brbf_pkg::t_in_item   i_in_data,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output brbf_pkg::t_out_item  o_out_data,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import brbf_pkg::*;

    logic             r_out_valid;
    t_out_item        r_out_data;
    logic [CNT_W-1:0] r_cap, n_cap;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_val;
    logic             busy;
    logic             res_valid;
    logic             res_take;
    t_out_item        res;
    t_ram_req         ram_req;
    logic [7:0]       ram_rdata;

    // config write decode and capacity clamp
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign cfg_val = pwdata[CNT_W-1:0];
    always_comb begin
        if (cfg_val == '0) begin
            n_cap = CNT_W'(1);
        end else if (cfg_val > CNT_W'(STORE_DEPTH)) begin
            n_cap = CNT_W'(STORE_DEPTH);
        end else begin
            n_cap = cfg_val;
        end
    end
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(STORE_DEPTH);
        end else if (cfg_we) begin
            r_cap <= n_cap;
        end
    end

    // input handshake
    assign o_in_stall = busy;

    // output register takes the result when empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // sequencer
    brbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !busy),
        .i_item      (i_in_data),
        .i_cap       (r_cap),
        .i_clr_ptrs  (cfg_we),
        .i_res_take  (res_take),
        .i_ram_rdata (ram_rdata),
        .o_ram_req   (ram_req),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // byte store
    brbf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

endmodule

### verif/tb_top.sv
// self-checking testbench for the block ring byte fifo
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brbf_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          LONG_HOLD    = 300;
    localparam int          IDLE_LIMIT   = 4000;

    // operation mix of the random traffic
    typedef enum int {
        MIX_EVEN,
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    // one line of the directed stimulus
    typedef struct {
        bit          is_cfg;
        logic [31:0] cfg_val;
        t_in_item    item;
        bit          has_exp;
        t_out_item   exp_res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the ring
    logic [7:0]  ring_mem [STORE_DEPTH];
    int unsigned rd_pos;
    int unsigned wr_pos;
    int unsigned ring_cap;
    bit          ring_full;

    t_out_item   pending_results_q[$];
    t_row        stim_table[$];
    bit          steady_tail;
    bit          hold_req;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_refused;
    int unsigned n_full_hits;
    int unsigned n_errors;

    block_ring_byte_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ring occupancy
    function automatic int unsigned ring_used();
        if (ring_full) return ring_cap;
        if (wr_pos >= rd_pos) return wr_pos - rd_pos;
        return ring_cap - (rd_pos - wr_pos);
    endfunction

    function automatic int unsigned ring_free();
        if (ring_full) return 0;
        return ring_cap - ring_used();
    endfunction

    function automatic void ring_clear();
        rd_pos    = 0;
        wr_pos    = 0;
        ring_full = 1'b0;
    endfunction

    // capacity write: low 11 bits, clamped to 1..depth, pointers cleared
    function automatic void ring_configure(input logic [31:0] val);
        int unsigned v;
        v = val[10:0];
        if (v == 0) v = 1;
        if (v > STORE_DEPTH) v = STORE_DEPTH;
        ring_cap = v;
        ring_clear();
    endfunction

    // predicted result of one transaction, updating the shadow ring
    function automatic t_out_item ring_step(input t_in_item it);
        t_out_item   res;
        int unsigned cnt;
        cnt           = it.byte_count;
        res.status    = ST_OK;
        res.read_data = '0;
        if (it.operation == OP_CLEAR) begin
            ring_clear();
        end else if (it.operation == OP_WRITE || it.operation == OP_READ) begin
            if (cnt == 0) begin
                res.status = ST_ZERO_COUNT;
            end else if (cnt > MAX_BLOCK_BYTES) begin
                res.status = ST_EXCEEDS_CAP;
            end else if (it.operation == OP_WRITE) begin
                if (cnt > ring_cap) begin
                    res.status = ST_EXCEEDS_CAP;
                end else if (cnt > ring_free()) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        ring_mem[wr_pos] = it.write_data[8*i +: 8];
                        wr_pos = (wr_pos + 1 == ring_cap) ? 0 : wr_pos + 1;
                    end
                    ring_full = (wr_pos == rd_pos);
                end
            end else begin
                if (cnt > ring_used()) begin
                    res.status = ST_NO_DATA;
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        res.read_data[8*i +: 8] = ring_mem[rd_pos];
                        rd_pos = (rd_pos + 1 == ring_cap) ? 0 : rd_pos + 1;
                    end
                    ring_full = 1'b0;
                end
            end
        end
        res.readable_count = CNT_W'(ring_used());
        res.writable_count = CNT_W'(ring_free());
        return res;
    endfunction

    // directed table builders
    function automatic void add_item(input logic [1:0] op, input int cnt, input logic [63:0] data);
        t_row row;
        row.is_cfg          = 1'b0;
        row.cfg_val         = '0;
        row.item.operation  = op;
        row.item.byte_count = BCNT_W'(cnt);
        row.item.write_data = data;
        row.has_exp         = 1'b0;
        row.exp_res         = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_check(input logic [1:0] op, input int cnt, input logic [63:0] data,
                                      input logic [2:0] st, input logic [63:0] rd,
                                      input int rc, input int wc);
        add_item(op, cnt, data);
        stim_table[$].has_exp                = 1'b1;
        stim_table[$].exp_res.status         = st;
        stim_table[$].exp_res.read_data      = rd;
        stim_table[$].exp_res.readable_count = CNT_W'(rc);
        stim_table[$].exp_res.writable_count = CNT_W'(wc);
    endfunction

    function automatic void add_cfg(input logic [31:0] val);
        add_item(OP_CLEAR, 0, '0);
        stim_table[$].is_cfg  = 1'b1;
        stim_table[$].cfg_val = val;
    endfunction

    // random transaction, mostly well-formed moves with some noise
    function automatic t_in_item random_item(input t_mix mix);
        t_in_item    it;
        int unsigned r;
        int unsigned wr_pct;
        it.write_data = {$urandom, $urandom};
        it.byte_count = BCNT_W'($urandom_range(1, MAX_BLOCK_BYTES));
        wr_pct = (mix == MIX_FILL) ? 90 : (mix == MIX_DRAIN) ? 25 : 50;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            it.operation  = 2'($urandom_range(0, 3));
            it.byte_count = '0;
        end else if (r < 5) begin
            it.operation  = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            it.byte_count = BCNT_W'($urandom_range(MAX_BLOCK_BYTES + 1, 15));
        end else if (r < 6) begin
            it.operation  = OP_UNUSED;
            it.byte_count = BCNT_W'($urandom_range(0, 15));
        end else if (r < 7 && mix != MIX_FILL) begin
            it.operation  = OP_CLEAR;
            it.byte_count = BCNT_W'($urandom_range(0, 15));
        end else begin
            it.operation = ($urandom_range(0, 99) < wr_pct) ? OP_WRITE : OP_READ;
        end
        return it;
    endfunction

    // offer one transaction and log its expected result once accepted
    task automatic drive_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item   predicted;
        int unsigned gap;
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = ring_step(it);
        pending_results_q.push_back(typed ? typed_res : predicted);
        n_items++;
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // capacity write over apb once the block has drained
    task automatic write_capacity(input logic [31:0] val);
        i_in_valid <= 1'b0;
        while (pending_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_configure(val);
    endtask

    // one capacity setting followed by random traffic
    task automatic run_phase(input logic [31:0] cap_val, input int count, input int fill,
                             input bit hold);
        t_mix mix;
        write_capacity(cap_val);
        if (hold) hold_req = 1'b1;
        mix = MIX_EVEN;
        for (int k = 0; k < count; k++) begin
            if (k < fill) mix = MIX_FILL;
            else if (k % 40 == 0) mix = t_mix'($urandom_range(0, 2));
            drive_item(random_item(mix), 1'b0, '0);
        end
    endtask

    // compare one accepted result with the oldest expectation
    function automatic void check_result(input t_out_item got);
        t_out_item want;
        n_results++;
        if (got.status != ST_OK) n_refused++;
        if (got.writable_count == 0) n_full_hits++;
        if (pending_results_q.size() == 0) begin
            $display("%0t: result with nothing pending: actual %p", $time, got);
            n_errors++;
            return;
        end
        want = pending_results_q.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            n_errors++;
        end
        if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want.read_data, got.read_data);
            n_errors++;
        end
        if (got.readable_count !== want.readable_count) begin
            $display("%0t: readable_count mismatch: expected %0d, actual %0d",
                     $time, want.readable_count, got.readable_count);
            n_errors++;
        end
        if (got.writable_count !== want.writable_count) begin
            $display("%0t: writable_count mismatch: expected %0d, actual %0d",
                     $time, want.writable_count, got.writable_count);
            n_errors++;
        end
    endfunction

    // result side: random stall bursts and one long hold-off
    initial begin : result_side
        int unsigned gap;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                check_result(o_out_data);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 9);
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0) ||
                i_rst_n !== 1'b1 || psel === 1'b1) begin
                dead_cycles = 0;
            end else begin
                dead_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("** block_ring_byte_fifo: FAILED **");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        steady_tail = 1'b0;
        hold_req    = 1'b0;
        n_items     = 0;
        n_results   = 0;
        n_refused   = 0;
        n_full_hits = 0;
        n_errors    = 0;
        ring_configure(STORE_DEPTH);

        // reset capacity: error codes, unused op, clear, block moves
        add_check(OP_WRITE, 0, ALL_ONES, ST_ZERO_COUNT, '0, 0, 1024);
        add_check(OP_READ, 0, '0, ST_ZERO_COUNT, '0, 0, 1024);
        add_check(OP_READ, 1, '0, ST_NO_DATA, '0, 0, 1024);
        add_check(OP_WRITE, 9, ALL_ONES, ST_EXCEEDS_CAP, '0, 0, 1024);
        add_check(OP_READ, 15, '0, ST_EXCEEDS_CAP, '0, 0, 1024);
        add_check(OP_UNUSED, 8, ALL_ONES, ST_OK, '0, 0, 1024);
        add_check(OP_WRITE, 8, ALL_ONES, ST_OK, '0, 8, 1016);
        add_check(OP_READ, 8, '0, ST_OK, ALL_ONES, 0, 1024);
        add_item(OP_WRITE, 1, 64'h5A);
        add_item(OP_WRITE, 8, 64'h0123_4567_89AB_CDEF);
        add_item(OP_READ, 3, '0);
        add_item(OP_READ, 6, '0);
        add_check(OP_CLEAR, 15, ALL_ONES, ST_OK, '0, 0, 1024);
        add_check(OP_READ, 9, '0, ST_EXCEEDS_CAP, '0, 0, 1024);
        // single slot ring
        add_cfg(32'd1);
        add_check(OP_WRITE, 2, '0, ST_EXCEEDS_CAP, '0, 0, 1);
        add_check(OP_WRITE, 1, 64'hA5, ST_OK, '0, 1, 0);
        add_check(OP_WRITE, 1, 64'h3C, ST_NO_SPACE, '0, 1, 0);
        add_check(OP_READ, 2, '0, ST_NO_DATA, '0, 1, 0);
        add_check(OP_READ, 1, '0, ST_OK, 64'hA5, 0, 1);
        // eight slot ring, fill across the wrap point
        add_cfg(32'd8);
        add_item(OP_WRITE, 6, 64'h1122_3344_5566_7788);
        add_item(OP_READ, 4, '0);
        add_item(OP_WRITE, 6, 64'h99AA_BBCC_DDEE_FF00);
        add_check(OP_WRITE, 1, 64'h77, ST_NO_SPACE, '0, 8, 0);
        add_item(OP_READ, 8, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[r]) begin
            if (stim_table[r].is_cfg) begin
                write_capacity(stim_table[r].cfg_val);
            end else begin
                drive_item(stim_table[r].item, stim_table[r].has_exp, stim_table[r].exp_res);
            end
        end

        // random traffic over several capacities, extremes included
        run_phase(32'd1024, 480, 330, 1'b1);
        run_phase(32'd0, 100, 0, 1'b0);
        run_phase(32'hFFFF_F805, 150, 0, 1'b0);
        run_phase(32'd8, 150, 0, 1'b0);
        run_phase(32'd9, 150, 0, 1'b0);
        run_phase(32'd13, 150, 0, 1'b0);
        run_phase(32'd2047, 120, 0, 1'b0);
        steady_tail = 1'b1;
        run_phase(32'd100, 260, 0, 1'b0);
        i_in_valid <= 1'b0;

        // drain
        while (pending_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions in, %0d results out, %0d refused",
                 n_items, n_results, n_refused);
        $display("ring seen full %0d times over capacities 1 to 1024, %0d mismatches",
                 n_full_hits, n_errors);
        if (n_errors == 0) begin
            $display("** block_ring_byte_fifo: PASSED **");
        end else begin
            $display("** block_ring_byte_fifo: FAILED **");
        end
        $finish;
    end

endmodule
